### hw/rtl/sdcs_pkg.sv
// ----------------------------------------------------------------------------
// sdcs_pkg
// Shared types, widths and codes of the shake display column sequencer.
// ----------------------------------------------------------------------------
package sdcs_pkg;

    // Frame store geometry
    localparam int MAX_FRAMES  = 16;
    localparam int MAX_COLUMNS = 32;
    localparam int FRAME_W     = $clog2(MAX_FRAMES);
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int COL_POS_W   = $clog2(MAX_COLUMNS + 1);
    localparam int FRAME_CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int STORE_DEPTH = MAX_FRAMES * MAX_COLUMNS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Item field widths
    localparam int OP_W      = 2;
    localparam int ACCEL_W   = 8;
    localparam int SFRAME_W  = 4;
    localparam int SCOL_W    = 5;
    localparam int LED_W     = 8;
    localparam int DIR_W     = 2;
    localparam int CURFRM_W  = 4;

    // Configuration register widths and reset values
    localparam int THR_W     = 7;
    localparam int SPF_W     = 8;
    localparam int FIU_W     = 5;
    localparam int CIU_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(60);
    localparam logic [SPF_W-1:0] SPF_RESET = SPF_W'(1);
    localparam logic [FIU_W-1:0] FIU_RESET = FIU_W'(16);
    localparam logic [CIU_W-1:0] CIU_RESET = CIU_W'(32);

    // Packed stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD        = 2'd0,
        REG_SHAKES_PER_FRAME = 2'd1,
        REG_FRAMES_IN_USE    = 2'd2,
        REG_COLUMNS_IN_USE   = 2'd3
    } reg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_STORE  = 2'd2
    } op_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_NONE = 2'd0,
        DIR_LTR  = 2'd1,
        DIR_RTL  = 2'd2
    } dir_t;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [SPF_W-1:0] shakes_per_frame;
        logic [FIU_W-1:0] frames_in_use;
        logic [CIU_W-1:0] columns_in_use;
    } cfg_t;

    // Outcome of one item, less the pattern byte that comes from the store
    typedef struct packed {
        logic                 paint;
        logic                 driven;
        dir_t                 dir;
        logic [FRAME_W-1:0]   frame;
    } res_t;

endpackage

### hw/rtl/shake_display_column_sequencer.sv
// ----------------------------------------------------------------------------
// shake_display_column_sequencer
// Column sequencer of a persistence-of-vision LED bar that is waved to and fro.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  s_      | in        | s_tvalid/s_tready  | tuser: op; tdata: accel_y,
//          |           |                    |   store_frame, store_column, store_byte
//  m_      | out       | m_tvalid/m_tready  | tdata: leds, leds_driven,
//          |           |                    |   moving_direction, current_frame
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One item per cycle while the m_ side is not stalled; each item gives exactly one
//  result, through the pending stage (frame store read) and then the output register.
//  The frame store RAM read port sets the latency: its registered read data is
//  joined with the item's control outcome in a pending stage.
//  Reset (aresetn, synchronous, active low) clears the swing state and the stream
//  valids and loads the register defaults; the frame store is not cleared.
//  A stalled m_ side holds the output register, then the pending stage, then
//  s_tready drops; configuration writes are always taken.
// ----------------------------------------------------------------------------
module shake_display_column_sequencer (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [7:0] accel_y, [11:8] store_frame, [16:12] store_column, [24:17] store_byte
    input  logic [sdcs_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] op
    input  logic [sdcs_pkg::OP_W-1:0]       s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] leds, [8] leds_driven, [10:9] moving_direction, [14:11] current_frame
    output logic [sdcs_pkg::M_TDATA_W-1:0]  m_tdata,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sdcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sdcs_pkg::CFG_DAT_W-1:0]  cfg_data
);
    import sdcs_pkg::*;

    // Unpacked input fields
    op_t                  s_op;
    logic [ACCEL_W-1:0]   s_accel_y;
    logic [SFRAME_W-1:0]  s_store_frame;
    logic [SCOL_W-1:0]    s_store_column;
    logic [LED_W-1:0]     s_store_byte;

    assign s_op           = op_t'(s_tuser);
    assign s_accel_y      = s_tdata[7:0];
    assign s_store_frame  = s_tdata[11:8];
    assign s_store_column = s_tdata[16:12];
    assign s_store_byte   = s_tdata[24:17];

    // Configuration registers
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold        <= THR_RESET;
            cfg_reg.shakes_per_frame <= SPF_RESET;
            cfg_reg.frames_in_use    <= FIU_RESET;
            cfg_reg.columns_in_use   <= CIU_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_idx_t'(cfg_index))
                REG_THRESHOLD:        cfg_reg.threshold        <= cfg_data[THR_W-1:0];
                REG_SHAKES_PER_FRAME: cfg_reg.shakes_per_frame <= cfg_data[SPF_W-1:0];
                REG_FRAMES_IN_USE:    cfg_reg.frames_in_use    <= cfg_data[FIU_W-1:0];
                REG_COLUMNS_IN_USE:   cfg_reg.columns_in_use   <= cfg_data[CIU_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Stream control: pending stage waits for RAM data, output register feeds m_
    logic       p1_valid_reg;
    res_t       p1_res_reg;
    logic       m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic       p1_advance, s_accept;

    assign p1_advance = !m_valid_reg || m_tready;
    assign s_tready   = !p1_valid_reg || p1_advance;
    assign s_accept   = s_tvalid && s_tready;

    // Swing tracking
    res_t                 core_res;
    logic [STORE_AW-1:0]  rd_addr;
    logic [LED_W-1:0]     rd_data;
    logic                 store_wr;

    sdcs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .op      (s_op),
        .accel_y (s_accel_y),
        .cfg     (cfg_reg),
        .res     (core_res),
        .rd_addr (rd_addr)
    );

    // Drop store writes that fall outside the store
    assign store_wr = s_accept && s_op == OP_STORE
                   && {1'b0, s_store_frame}  < (SFRAME_W + 1)'(MAX_FRAMES)
                   && {1'b0, s_store_column} < (SCOL_W + 1)'(MAX_COLUMNS);

    sdcs_ram #(
        .WIDTH (LED_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (store_wr),
        .wr_addr ({s_store_frame[FRAME_W-1:0], s_store_column[COL_W-1:0]}),
        .wr_data (s_store_byte),
        .rd_en   (s_accept && core_res.paint),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                p1_valid_reg <= 1'b1;
            end else if (p1_advance) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_advance) begin
                m_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_res_reg <= core_res;
        end
        if (p1_advance && p1_valid_reg) begin
            m_data_reg <= {1'b0,
                           CURFRM_W'(p1_res_reg.frame),
                           p1_res_reg.dir,
                           p1_res_reg.driven,
                           p1_res_reg.paint ? rd_data : LED_W'(0)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A pattern only ever goes out on a beat that drives the bar
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[8] |-> m_tdata[7:0] == '0)
        else $error("pattern on an undriven beat");

    // The input side never stalls while the output can drain
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg || m_tready |-> s_tready)
        else $error("input stalled with free output");

    // Store read data holds while its painting beat waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && p1_res_reg.paint && !p1_advance
        |=> p1_valid_reg && $stable(rd_data))
        else $error("pending store data disturbed");

endmodule

### hw/rtl/sdcs_ram.sv
// ----------------------------------------------------------------------------
// sdcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sdcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/sdcs_core.sv
// ----------------------------------------------------------------------------
// sdcs_core
// Swing tracking state: extreme search, direction, column and frame position.
// ----------------------------------------------------------------------------
module sdcs_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  sdcs_pkg::op_t                  op,
    input  logic [sdcs_pkg::ACCEL_W-1:0]   accel_y,
    input  sdcs_pkg::cfg_t                 cfg,
    output sdcs_pkg::res_t                 res,
    output logic [sdcs_pkg::STORE_AW-1:0]  rd_addr
);
    import sdcs_pkg::*;

    dir_t                   dir_reg,   dir_next;
    logic [ACCEL_W-1:0]     ext_reg,   ext_next;
    logic [COL_POS_W-1:0]   col_reg,   col_next;
    logic [FRAME_W-1:0]     frame_reg, frame_next;
    logic [SPF_W-1:0]       shake_reg, shake_next;

    logic signed [ACCEL_W:0] a_s, th_pos, th_neg, ext_s;
    logic [COL_POS_W-1:0]    eff_cols, paint_col;
    logic [FRAME_CNT_W-1:0]  eff_frames, frame_inc;
    logic [SPF_W-1:0]        spf, shake_inc;
    logic                    paint_try, paint, driven;

    always_comb begin
        a_s    = {accel_y[ACCEL_W-1], accel_y};
        ext_s  = {ext_reg[ACCEL_W-1], ext_reg};
        th_pos = {{(ACCEL_W + 1 - THR_W){1'b0}}, cfg.threshold};
        th_neg = -th_pos;

        eff_cols = (cfg.columns_in_use > CIU_W'(MAX_COLUMNS)) ? COL_POS_W'(MAX_COLUMNS)
                                                                : COL_POS_W'(cfg.columns_in_use);
        if (cfg.frames_in_use == '0) begin
            eff_frames = FRAME_CNT_W'(1);
        end else if (cfg.frames_in_use > FIU_W'(MAX_FRAMES)) begin
            eff_frames = FRAME_CNT_W'(MAX_FRAMES);
        end else begin
            eff_frames = FRAME_CNT_W'(cfg.frames_in_use);
        end
        spf       = (cfg.shakes_per_frame == '0) ? SPF_W'(1) : cfg.shakes_per_frame;
        shake_inc = shake_reg + SPF_W'(1);
        frame_inc = {1'b0, frame_reg} + FRAME_CNT_W'(1);

        dir_next   = dir_reg;
        ext_next   = ext_reg;
        col_next   = col_reg;
        frame_next = frame_reg;
        shake_next = shake_reg;
        paint_try  = 1'b0;
        driven     = 1'b0;
        paint_col  = col_reg;

        case (op)
            OP_SAMPLE: begin
                if (a_s > th_pos && dir_reg != DIR_LTR) begin
                    if (a_s > ext_s) begin
                        ext_next = accel_y;
                    end else begin
                        // left extreme: restart the sweep from the first column
                        dir_next  = DIR_LTR;
                        paint_col = '0;
                        col_next  = '0;
                        paint_try = 1'b1;
                        driven    = 1'b1;
                    end
                end else if (a_s < th_neg && dir_reg != DIR_RTL) begin
                    if (a_s < ext_s) begin
                        ext_next = accel_y;
                    end else begin
                        dir_next = DIR_RTL;
                        if (shake_inc >= spf) begin
                            shake_next = '0;
                            frame_next = (frame_inc >= eff_frames) ? '0
                                                                   : frame_inc[FRAME_W-1:0];
                        end else begin
                            shake_next = shake_inc;
                        end
                    end
                end
            end
            OP_TICK: begin
                paint_try = 1'b1;
                driven    = 1'b1;
            end
            default: begin
            end
        endcase

        paint = paint_try && dir_next == DIR_LTR && paint_col < eff_cols;
        if (paint) begin
            col_next = paint_col + COL_POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg   <= DIR_NONE;
            ext_reg   <= '0;
            col_reg   <= '0;
            frame_reg <= '0;
            shake_reg <= '0;
        end else if (accept) begin
            dir_reg   <= dir_next;
            ext_reg   <= ext_next;
            col_reg   <= col_next;
            frame_reg <= frame_next;
            shake_reg <= shake_next;
        end
    end

    assign rd_addr = {frame_reg, paint_col[COL_W-1:0]};

    assign res.paint  = paint;
    assign res.driven = driven;
    assign res.dir    = dir_next;
    assign res.frame  = frame_next;

    // the column never runs past the end of the store row
    assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= COL_POS_W'(MAX_COLUMNS))
        else $error("column position past last column");

    // a fresh right extreme never leaves the shake count at or above its limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && dir_next == DIR_RTL && dir_reg != DIR_RTL && op == OP_SAMPLE
        |=> shake_reg < spf || $past(cfg.shakes_per_frame) != cfg.shakes_per_frame)
        else $error("shake counter not cleared at frame advance");

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the shake display column sequencer. Items are
// queued by a stimulus process and sent by a clocked driver. A clocked monitor
// models the swing tracking, column painting and frame stepping, and checks
// every result beat field by field against the oldest prediction. Both stream
// sides idle at random, and the result side holds off for long stretches.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sdcs_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 6;
    localparam int RANDOM_PER_PHASE = 155;
    localparam int PHASES           = 11;
    localparam int HOLD_CYCLES      = 300;
    localparam int SETTLE_CYCLES    = 6;     // pending stage and output register plus margin
    localparam int CYCLE_LIMIT      = 800_000;

    // Fourth op code: no enum member in the package, the block ignores it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_EVERY, IDLE_SOMETIMES} idle_mode_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [ACCEL_W-1:0]  accel;
        logic [SFRAME_W-1:0] sframe;
        logic [SCOL_W-1:0]   scol;
        logic [LED_W-1:0]    sbyte;
    } item_t;

    typedef struct packed {
        dir_t                dir;
        logic [ACCEL_W-1:0]  peak;      // signed running extreme
        logic [COL_POS_W-1:0] col;
        logic [FRAME_W-1:0]  frame;
        logic [SPF_W-1:0]    shakes;
    } swing_t;

    typedef struct packed {
        logic [LED_W-1:0]    leds;
        logic                driven;
        logic [DIR_W-1:0]    dir;
        logic [CURFRM_W-1:0] frame;
    } bar_update_t;

    // ------------------------------------------------------------------------
    // DUT signals, all testbench-driven ones known from time zero
    // ------------------------------------------------------------------------
    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    // ------------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------------
    cfg_t        settings = '{THR_RESET, SPF_RESET, FIU_RESET, CIU_RESET};
    swing_t      planned_swing = '0;     // swing state as the item queue leaves it
    swing_t      live_swing    = '0;     // swing state after the last accepted beat
    logic        loaded [STORE_DEPTH];   // entries written by some queued item
    logic [7:0]  bar_store [STORE_DEPTH];
    item_t       items_to_send[$];
    bar_update_t bar_updates_due[$];
    int          items_made;
    int          mismatches = 0;
    idle_mode_t  send_mode = IDLE_NONE;
    idle_mode_t  recv_mode = IDLE_NONE;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          gap_left   = 0;
    int          stall_left = 0;
    int          hold_left  = 0;
    int unsigned cycle_count = 0;

    shake_display_column_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Swing predictor: apply one item to a swing state. Report whether a column
    // is painted and from which store entry, and whether the bar is driven.
    // ------------------------------------------------------------------------
    function automatic void advance_swing(input cfg_t c, input item_t it, inout swing_t s,
                                          output logic paints, output logic [STORE_AW-1:0] addr,
                                          output logic driven);
        int   a;
        int   th;
        int   cols;
        int   frames;
        int   spf;
        logic want_paint;
        a      = $signed(it.accel);
        th     = int'(c.threshold);
        cols   = (c.columns_in_use > MAX_COLUMNS) ? MAX_COLUMNS : int'(c.columns_in_use);
        frames = (c.frames_in_use == 0) ? 1 :
                 (c.frames_in_use > MAX_FRAMES) ? MAX_FRAMES : int'(c.frames_in_use);
        spf    = (c.shakes_per_frame == 0) ? 1 : int'(c.shakes_per_frame);
        paints     = 1'b0;
        addr       = '0;
        driven     = 1'b0;
        want_paint = 1'b0;
        case (it.op)
            OP_SAMPLE: begin
                if (a > th && s.dir != DIR_LTR) begin
                    if (a > $signed(s.peak)) begin
                        s.peak = 8'(a);
                    end else begin
                        // left extreme: restart the sweep and paint column 0 now
                        s.dir      = DIR_LTR;
                        s.col      = '0;
                        want_paint = 1'b1;
                        driven     = 1'b1;
                    end
                end else if (a < -th && s.dir != DIR_RTL) begin
                    if (a < $signed(s.peak)) begin
                        s.peak = 8'(a);
                    end else begin
                        // right extreme: count the shake, step the frame when due
                        s.dir    = DIR_RTL;
                        s.shakes = s.shakes + 8'd1;
                        if (int'(s.shakes) >= spf) begin
                            s.shakes = '0;
                            if (int'(s.frame) + 1 >= frames)
                                s.frame = '0;
                            else
                                s.frame = s.frame + 4'd1;
                        end
                    end
                end
            end
            OP_TICK: begin
                want_paint = 1'b1;
                driven     = 1'b1;
            end
            default: ;
        endcase
        if (want_paint && s.dir == DIR_LTR && int'(s.col) < cols) begin
            paints = 1'b1;
            addr   = {s.frame, s.col[COL_W-1:0]};
            s.col  = s.col + 6'd1;
        end
    endfunction

    function automatic int idle_cycles(input idle_mode_t mode);
        case (mode)
            IDLE_EVERY:     return $urandom_range(18, 0);
            IDLE_SOMETIMES: return ($urandom_range(7, 0) == 0) ? $urandom_range(18, 1) : 0;
            default:        return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------
    function automatic item_t any_item();
        item_t it;
        it.op     = OP_W'($urandom_range(3, 0));
        it.accel  = ACCEL_W'($urandom);
        it.sframe = SFRAME_W'($urandom);
        it.scol   = SCOL_W'($urandom);
        it.sbyte  = LED_W'($urandom);
        return it;
    endfunction

    function automatic item_t sample_of(input logic [ACCEL_W-1:0] v);
        item_t it;
        it       = any_item();
        it.op    = OP_SAMPLE;
        it.accel = v;
        return it;
    endfunction

    function automatic item_t tick_item();
        item_t it;
        it    = any_item();
        it.op = OP_TICK;
        return it;
    endfunction

    function automatic item_t store_of(input logic [SFRAME_W-1:0] f,
                                       input logic [SCOL_W-1:0] c, input logic [7:0] b);
        item_t it;
        it        = any_item();
        it.op     = OP_STORE;
        it.sframe = f;
        it.scol   = c;
        it.sbyte  = b;
        return it;
    endfunction

    // Queue an item. Load a store entry first if the item would paint one that
    // was never written, so no beat ever shows undefined store contents.
    function automatic void add_item(input item_t it);
        swing_t              probe;
        logic                paints;
        logic                driven;
        logic [STORE_AW-1:0] addr;
        probe = planned_swing;
        advance_swing(settings, it, probe, paints, addr, driven);
        if (paints && !loaded[addr]) begin
            items_to_send.push_back(store_of(addr[STORE_AW-1:COL_W], addr[COL_W-1:0],
                                             8'($urandom)));
            loaded[addr] = 1'b1;
            items_made++;
        end
        if (it.op == OP_STORE)
            loaded[{it.sframe, it.scol}] = 1'b1;
        items_to_send.push_back(it);
        planned_swing = probe;
        items_made++;
    endfunction

    // One full shake: climb past +threshold (if below 127), fall back, tick across the bar,
    // dive past -threshold, rise back, then a few blank ticks.
    function automatic void add_swing();
        int th;
        int peak;
        int reps;
        int k;
        th = int'(settings.threshold);
        if (th < 127) begin
            peak = $urandom_range(127, th + 1);
            reps = $urandom_range(2, 0);
            for (k = 0; k < reps; k++)
                add_item(sample_of(8'($urandom_range(peak, th + 1))));
            add_item(sample_of(8'(peak)));
            add_item(sample_of(8'($urandom_range(peak, th + 1))));
        end
        reps = $urandom_range(((settings.columns_in_use > MAX_COLUMNS) ?
                               MAX_COLUMNS : int'(settings.columns_in_use)) + 3, 0);
        for (k = 0; k < reps; k++)
            add_item(tick_item());
        peak = $urandom_range(128, th + 1);
        reps = $urandom_range(2, 0);
        for (k = 0; k < reps; k++)
            add_item(sample_of(8'(-int'($urandom_range(peak, th + 1)))));
        add_item(sample_of(8'(-peak)));
        add_item(sample_of(8'(-int'($urandom_range(peak, th + 1)))));
        reps = $urandom_range(4, 0);
        for (k = 0; k < reps; k++)
            add_item(tick_item());
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer queued items, drawing a gap after each one
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive_items
        item_t beat;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (items_to_send.size() != 0) begin
                beat = items_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, beat.sbyte, beat.scol, beat.sframe, beat.accel};
                s_tuser  <= beat.op;
                gap_left <= idle_cycles(send_mode);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check result beats, predict for accepted items, pace m_tready
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : watch_bar
        item_t               taken;
        bar_update_t         due;
        bar_update_t         fresh;
        logic                paints;
        logic                driven;
        logic [STORE_AW-1:0] addr;
        int                  stall;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end else begin
            // check first: a beat leaving now never belongs to an item taken now
            if (m_tvalid && m_tready) begin
                if (bar_updates_due.size() == 0) begin
                    $error("result beat with nothing due: m_tdata %h", m_tdata);
                    mismatches++;
                end else begin
                    due = bar_updates_due.pop_front();
                    if (m_tdata[7:0] !== due.leds) begin
                        $error("leds: expected %0h, got %0h", due.leds, m_tdata[7:0]);
                        mismatches++;
                    end
                    if (m_tdata[8] !== due.driven) begin
                        $error("leds_driven: expected %0d, got %0d", due.driven, m_tdata[8]);
                        mismatches++;
                    end
                    if (m_tdata[10:9] !== due.dir) begin
                        $error("moving_direction: expected %0d, got %0d",
                               due.dir, m_tdata[10:9]);
                        mismatches++;
                    end
                    if (m_tdata[14:11] !== due.frame) begin
                        $error("current_frame: expected %0d, got %0d",
                               due.frame, m_tdata[14:11]);
                        mismatches++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                taken.op     = s_tuser;
                taken.accel  = s_tdata[7:0];
                taken.sframe = s_tdata[11:8];
                taken.scol   = s_tdata[16:12];
                taken.sbyte  = s_tdata[24:17];
                advance_swing(settings, taken, live_swing, paints, addr, driven);
                if (taken.op == OP_STORE)
                    bar_store[{taken.sframe, taken.scol}] = taken.sbyte;
                fresh.leds   = paints ? bar_store[addr] : 8'h00;
                fresh.driven = driven;
                fresh.dir    = live_swing.dir;
                fresh.frame  = live_swing.frame;
                bar_updates_due.push_back(fresh);
            end

            // A fresh hold-off request wins; otherwise stall after each beat
            if (hold_requests != hold_served) begin
                hold_served <= hold_requests;
                hold_left   <= HOLD_CYCLES;
                m_tready    <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                stall = idle_cycles(recv_mode);
                stall_left <= stall;
                m_tready   <= (stall == 0);
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= (stall_left == 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if the stimulus never drains
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic put_reg(input reg_idx_t idx, input logic [CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Wait until every queued item has left and every result has arrived;
    // sample between edges so the driver and monitor have settled
    task automatic settle();
        do @(negedge aclk);
        while (items_to_send.size() != 0 || s_tvalid || bar_updates_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : run_phases
        cfg_t  plan [8];
        cfg_t  want;
        item_t odd;
        int    p;
        int    i;

        // Boundary settings: zero threshold, one frame, one column, saturated
        // shake count, zero and over-range registers, frames below the position
        plan = '{'{7'd0,   8'd1,   5'd1,  6'd1},
                 '{7'd50,  8'd255, 5'd16, 6'd32},
                 '{7'd30,  8'd2,   5'd3,  6'd5},
                 '{7'd127, 8'd4,   5'd8,  6'd16},
                 '{7'd20,  8'd0,   5'd0,  6'd0},
                 '{7'd40,  8'd3,   5'd31, 6'd63},
                 '{7'd100, 8'd1,   5'd16, 6'd32},
                 '{7'd70,  8'd1,   5'd2,  6'd33}};
        for (i = 0; i < STORE_DEPTH; i++)
            loaded[i] = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                if (p <= 8) begin
                    want = plan[p - 1];
                end else begin
                    want.threshold        = THR_W'($urandom_range(127, 0));
                    want.shakes_per_frame = SPF_W'($urandom_range(6, 0));
                    want.frames_in_use    = FIU_W'($urandom_range(31, 0));
                    want.columns_in_use   = CIU_W'($urandom_range(63, 0));
                end
                put_reg(REG_THRESHOLD,        8'(want.threshold));
                put_reg(REG_SHAKES_PER_FRAME, 8'(want.shakes_per_frame));
                put_reg(REG_FRAMES_IN_USE,    8'(want.frames_in_use));
                put_reg(REG_COLUMNS_IN_USE,   8'(want.columns_in_use));
                cfg_valid <= 1'b0;
                settings = want;
            end

            // Hold off the result side while the sender streams flat out, or
            // draw fresh idling for both sides
            if (p == 2 || $urandom_range(3, 0) == 0) begin
                send_mode     <= IDLE_NONE;
                recv_mode     <= idle_mode_t'($urandom_range(2, 0));
                hold_requests <= hold_requests + 1;
            end else begin
                send_mode <= idle_mode_t'($urandom_range(2, 0));
                recv_mode <= idle_mode_t'($urandom_range(2, 0));
            end

            if (p == 0) begin
                add_item(tick_item());                      // direction still unknown
                odd    = any_item();
                odd.op = OP_UNUSED;
                add_item(odd);
                add_item(store_of(4'hF, 5'h1F, 8'hFF));
                add_item(store_of(4'h0, 5'h00, 8'h00));
                add_item(sample_of(8'd0));
                add_item(sample_of(8'd60));                 // at threshold: no search
                add_item(sample_of(8'd127));
                add_item(sample_of(8'd127));                // left extreme, paint
                add_item(tick_item());
                add_item(tick_item());
                add_item(sample_of(8'd100));                // ignored while sweeping
                add_item(sample_of(8'(-60)));
                add_item(sample_of(8'h80));
                add_item(sample_of(8'h80));                 // right extreme, next frame
                add_item(tick_item());                      // blank on the way back
                add_item(sample_of(8'd61));
                add_item(sample_of(8'd61));
                add_item(tick_item());
                add_item(sample_of(8'(-61)));
                add_item(sample_of(8'(-61)));
            end

            // Mostly whole shakes, the rest loose items of every kind
            items_made = 0;
            while (items_made < RANDOM_PER_PHASE) begin
                if ($urandom_range(9, 0) < 7) begin
                    add_swing();
                end else begin
                    odd = any_item();
                    if (odd.op == OP_UNUSED && $urandom_range(3, 0) != 0)
                        odd.op = OP_TICK;
                    add_item(odd);
                end
            end
            settle();
        end

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
